// ----- hdl/cbm_pkg.sv -----
// shared types, codes and mask functions for the cartridge bank mapper
`default_nettype none
package cbm_pkg;

   localparam int unsigned AddrWidth   = 16;
   localparam int unsigned DataWidth   = 8;
   localparam int unsigned MapWidth    = 21;
   localparam int unsigned BankShift   = 14;
   localparam int unsigned CsrIdxWidth = 2;
   localparam int unsigned CsrWidth    = 3;

   typedef enum logic [2:0] {
      TargetNone = 3'd0,
      TargetBoot = 3'd1,
      TargetRom  = 3'd2,
      TargetRam  = 3'd3,
      TargetReg  = 3'd4
   } cbm_target_type;

   typedef enum logic [1:0] {
      RegRamEnable = 2'd0,
      RegBankLow   = 2'd1,
      RegBankHigh  = 2'd2,
      RegMode      = 2'd3
   } cbm_mbc_reg_type;

   localparam logic [2:0] RegBootOverlay = 3'd4;

   typedef enum logic [1:0] {
      CsrCartridgeLoaded = 2'd0,
      CsrMapperBanked    = 2'd1,
      CsrRomSizeCode     = 2'd2,
      CsrRamSizeCode     = 2'd3
   } cbm_csr_index_type;

   localparam logic [15:0] BootOverlayAddr = 16'hFF50;
   localparam logic [3:0]  RamEnableKey    = 4'hA;

   typedef struct packed {
      logic                 op;
      logic [AddrWidth-1:0] bus_address;
      logic [DataWidth-1:0] write_data;
   } cbm_item_type;

   typedef struct packed {
      cbm_target_type      target;
      logic [MapWidth-1:0] mapped_address;
      logic                ram_access_ok;
   } cbm_result_type;

   typedef struct packed {
      logic       cartridge_loaded;
      logic       mapper_banked;
      logic [2:0] rom_size_code;
      logic [1:0] ram_size_code;
   } cbm_cfg_type;

   typedef struct packed {
      logic       ram_enabled;
      logic [4:0] bank_low;
      logic [1:0] bank_high;
      logic       advanced_mode;
      logic       boot_overlay;
   } cbm_state_type;

   // controller state after reset: boot rom mapped, everything else clear
   localparam cbm_state_type StateReset = '{
      ram_enabled:   1'b0,
      bank_low:      5'd0,
      bank_high:     2'd0,
      advanced_mode: 1'b0,
      boot_overlay:  1'b1
   };

   function automatic logic [MapWidth-1:0] rom_mask(input logic [2:0] code);
      logic [MapWidth-1:0] mask;
      unique case (code)
         3'd0: mask = 21'h007FFF;
         3'd1: mask = 21'h00FFFF;
         3'd2: mask = 21'h01FFFF;
         3'd3: mask = 21'h03FFFF;
         3'd4: mask = 21'h07FFFF;
         3'd5: mask = 21'h0FFFFF;
         default: mask = 21'h1FFFFF;
      endcase
      return mask;
   endfunction

   function automatic logic [14:0] ram_mask(input logic [1:0] code);
      logic [14:0] mask;
      unique case (code)
         2'd1: mask = 15'h07FF;
         2'd2: mask = 15'h1FFF;
         default: mask = 15'h7FFF;
      endcase
      return mask;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/cbm_if.sv -----
// valid/ready channel interfaces for bus accesses and mapping results
`default_nettype none
interface cbm_req_if;
   logic                          valid;
   logic                          ready;
   logic                          op;
   logic [cbm_pkg::AddrWidth-1:0] bus_address;
   logic [cbm_pkg::DataWidth-1:0] write_data;

   modport source (output valid, output op, output bus_address, output write_data,
                   input ready);
   modport sink   (input valid, input op, input bus_address, input write_data,
                   output ready);
endinterface

interface cbm_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [2:0]                   target;
   logic [cbm_pkg::MapWidth-1:0] mapped_address;
   logic                         ram_access_ok;

   modport source (output valid, output target, output mapped_address,
                   output ram_access_ok, input ready);
   modport sink   (input valid, input target, input mapped_address,
                   input ram_access_ok, output ready);
endinterface
`default_nettype wire

// ----- hdl/cartridge_bank_mapper.sv -----
// cartridge bank mapper top level: input register, decode, result register
// throughput: one access per cycle while the rsp channel is not stalled; the input register feeds decode, whose result
//   and controller state update are captured in the same cycle
// reset: synchronous, active high; clears configuration, bank state, ram enable,
//   sets the boot overlay and empties both pipeline registers
`default_nettype none
module cartridge_bank_mapper (
   input  wire logic                            clock,
   input  wire logic                            reset,
   cbm_req_if.sink                              req_chan,
   cbm_rsp_if.source                            rsp_chan,
   input  wire logic                            csr_write_enable,
   input  wire logic [cbm_pkg::CsrIdxWidth-1:0] csr_index,
   input  wire logic [cbm_pkg::CsrWidth-1:0]    csr_write_data
);

   logic                    in_valid_ff, in_valid_in;
   cbm_pkg::cbm_item_type   in_item_ff, in_item_in;
   logic                    out_valid_ff, out_valid_in;
   cbm_pkg::cbm_result_type out_result_ff, out_result_in;

   cbm_pkg::cbm_cfg_type    cfg;
   cbm_pkg::cbm_state_type  state;
   cbm_pkg::cbm_state_type  next_state;
   cbm_pkg::cbm_result_type result;

   logic out_free;
   logic advance;
   logic req_take;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign advance  = in_valid_ff && out_free;
   assign req_take = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !in_valid_ff || advance;

   cbm_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   cbm_state u_state (
      .clock      (clock),
      .reset      (reset),
      .update     (advance),
      .next_state (next_state),
      .state      (state)
   );

   cbm_decode u_decode (
      .item       (in_item_ff),
      .cfg        (cfg),
      .state      (state),
      .next_state (next_state),
      .result     (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_take) begin
         in_valid_in            = 1'b1;
         in_item_in.op          = req_chan.op;
         in_item_in.bus_address = req_chan.bus_address;
         in_item_in.write_data  = req_chan.write_data;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_result_in = out_result_ff;
      if (advance) begin
         out_valid_in  = 1'b1;
         out_result_in = result;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff    <= in_item_in;
      out_result_ff <= out_result_in;
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.target         = out_result_ff.target;
   assign rsp_chan.mapped_address = out_result_ff.mapped_address;
   assign rsp_chan.ram_access_ok  = out_result_ff.ram_access_ok;

endmodule
`default_nettype wire

// ----- hdl/cbm_csr.sv -----
// configuration registers written through the csr port
`default_nettype none
module cbm_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write_enable,
   input  wire logic [cbm_pkg::CsrIdxWidth-1:0] csr_index,
   input  wire logic [cbm_pkg::CsrWidth-1:0]    csr_write_data,
   output cbm_pkg::cbm_cfg_type                 cfg
);

   cbm_pkg::cbm_cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (cbm_pkg::cbm_csr_index_type'(csr_index))
            cbm_pkg::CsrCartridgeLoaded: cfg_in.cartridge_loaded = csr_write_data[0];
            cbm_pkg::CsrMapperBanked:    cfg_in.mapper_banked    = csr_write_data[0];
            cbm_pkg::CsrRomSizeCode:     cfg_in.rom_size_code    = csr_write_data;
            cbm_pkg::CsrRamSizeCode:     cfg_in.ram_size_code    = csr_write_data[1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ----- hdl/cbm_state.sv -----
// controller state: ram enable, bank registers, mode and boot overlay
`default_nettype none
module cbm_state (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   update,
   input  wire cbm_pkg::cbm_state_type next_state,
   output cbm_pkg::cbm_state_type      state
);

   cbm_pkg::cbm_state_type state_ff, state_in;

   assign state_in = update ? next_state : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cbm_pkg::StateReset;
      end else begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

endmodule
`default_nettype wire

// ----- hdl/cbm_decode.sv -----
// address decode, bank mapping and register write decode for one transaction
`default_nettype none
module cbm_decode (
   input  wire cbm_pkg::cbm_item_type  item,
   input  wire cbm_pkg::cbm_cfg_type   cfg,
   input  wire cbm_pkg::cbm_state_type state,
   output cbm_pkg::cbm_state_type      next_state,
   output cbm_pkg::cbm_result_type     result
);

   logic [cbm_pkg::AddrWidth-1:0] addr;
   logic [6:0]                    rom_bank;
   logic [4:0]                    low_eff;
   logic [1:0]                    ram_bank;
   logic [cbm_pkg::MapWidth-1:0]  rom_addr;
   logic [14:0]                   ram_addr;
   logic                          advanced;

   assign addr     = item.bus_address;
   assign advanced = cfg.mapper_banked & state.advanced_mode;
   assign low_eff  = (state.bank_low == 5'd0) ? 5'd1 : state.bank_low;

   always_comb begin
      if (!addr[14]) begin
         rom_bank = advanced ? {state.bank_high, 5'd0} : 7'd0;
      end else if (cfg.mapper_banked) begin
         rom_bank = {state.bank_high, low_eff};
      end else begin
         rom_bank = 7'd1;
      end
   end

   assign rom_addr = {rom_bank, addr[cbm_pkg::BankShift-1:0]} &
                     cbm_pkg::rom_mask(cfg.rom_size_code);
   assign ram_bank = advanced ? state.bank_high : 2'd0;
   assign ram_addr = {ram_bank, addr[12:0]} & cbm_pkg::ram_mask(cfg.ram_size_code);

   always_comb begin
      next_state            = state;
      result.target         = cbm_pkg::TargetNone;
      result.mapped_address = '0;
      if (cfg.cartridge_loaded) begin
         priority if (!addr[15]) begin
            if (item.op) begin
               unique case (cbm_pkg::cbm_mbc_reg_type'(addr[14:13]))
                  cbm_pkg::RegRamEnable:
                     next_state.ram_enabled = (item.write_data[3:0] == cbm_pkg::RamEnableKey);
                  cbm_pkg::RegBankLow:   next_state.bank_low      = item.write_data[4:0];
                  cbm_pkg::RegBankHigh:  next_state.bank_high     = item.write_data[1:0];
                  cbm_pkg::RegMode:      next_state.advanced_mode = item.write_data[0];
                  default:               next_state               = state;
               endcase
               result.target         = cbm_pkg::TargetReg;
               result.mapped_address = {19'd0, addr[14:13]};
            end else if (!addr[14] && state.boot_overlay && addr[15:8] == 8'd0) begin
               result.target         = cbm_pkg::TargetBoot;
               result.mapped_address = {13'd0, addr[7:0]};
            end else begin
               result.target         = cbm_pkg::TargetRom;
               result.mapped_address = rom_addr;
            end
         end else if (addr[15:13] == 3'b101) begin
            if (cfg.ram_size_code != 2'd0) begin
               result.target         = cbm_pkg::TargetRam;
               result.mapped_address = {6'd0, ram_addr};
            end
         end else if (addr == cbm_pkg::BootOverlayAddr) begin
            if (item.op && item.write_data != 8'd0) begin
               next_state.boot_overlay = 1'b0;
            end
            result.target         = cbm_pkg::TargetReg;
            result.mapped_address = {18'd0, cbm_pkg::RegBootOverlay};
         end else begin
            result.target = cbm_pkg::TargetNone;
         end
      end
      // ram permission follows the enable as updated by this transaction
      result.ram_access_ok = cfg.cartridge_loaded & (cfg.ram_size_code != 2'd0) &
                             next_state.ram_enabled;
   end

endmodule
`default_nettype wire

// ----- hdl/cbm_checker.sv -----
// port-level checks for the cartridge bank mapper and their bind
`default_nettype none
module cbm_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic [2:0]                   rsp_target,
   input wire logic [cbm_pkg::MapWidth-1:0] rsp_mapped_address
);

   // a stalled result holds its transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_target) &&
                                  $stable(rsp_mapped_address))
      else $error("stalled result changed");

   // nothing comes out right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_target == cbm_pkg::TargetNone |-> rsp_mapped_address == '0)
      else $error("unmapped access with nonzero address");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_target == cbm_pkg::TargetBoot |-> rsp_mapped_address[20:8] == '0)
      else $error("boot rom address out of range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_target == cbm_pkg::TargetReg |->
         rsp_mapped_address <= cbm_pkg::MapWidth'(cbm_pkg::RegBootOverlay))
      else $error("register number out of range");

endmodule

bind cartridge_bank_mapper cbm_checker u_cbm_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_target         (rsp_chan.target),
   .rsp_mapped_address (rsp_chan.mapped_address)
);
`default_nettype wire

// ----- tb/cartridge_bank_mapper_tb.sv -----
// self-checking testbench: directed and random bus accesses through the cartridge bank mapper
`timescale 1ns / 1ps
module cartridge_bank_mapper_tb;

   localparam int unsigned ClockPeriod = 4;
   localparam int unsigned ResetCycles = 12;
   localparam int unsigned BankBytes   = 16384;
   localparam int unsigned PhaseItems  = 172;
   localparam int unsigned NumPhases   = 10;
   localparam int unsigned LongHold    = 80;
   localparam int unsigned StallLimit  = 2000;
   localparam logic        OpRead      = 1'b0;
   localparam logic        OpWrite     = 1'b1;

   logic clock = 1'b0;
   logic reset;
   logic                            csr_write_enable;
   logic [cbm_pkg::CsrIdxWidth-1:0] csr_index;
   logic [cbm_pkg::CsrWidth-1:0]    csr_write_data;

   cbm_req_if req_bus ();
   cbm_rsp_if rsp_bus ();

   cartridge_bank_mapper dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #(ClockPeriod / 2) clock = ~clock;

   cbm_pkg::cbm_item_type   pending_accesses[$];
   cbm_pkg::cbm_result_type expected_mappings[$];
   cbm_pkg::cbm_item_type   offered_access;
   cbm_pkg::cbm_result_type next_mapping;
   cbm_pkg::cbm_cfg_type    cart_cfg;
   cbm_pkg::cbm_state_type  mbc_state;

   int unsigned req_gap_left;
   int unsigned rsp_hold_left;
   bit          rsp_hold_request;
   bit          steady_tail;
   int unsigned idle_cycles;
   int unsigned mismatches;
   int unsigned checked_count;
   int unsigned config_count;
   int unsigned target_seen[5];

   // bank mapping prediction, updates the controller state copy
   function automatic cbm_pkg::cbm_result_type map_access(input cbm_pkg::cbm_item_type acc);
      cbm_pkg::cbm_result_type res;
      logic [15:0]    a;
      logic [6:0]     rom_bank;
      logic [1:0]     ram_bank;
      logic [2:0]     size_code;
      logic [31:0]    rom_span;
      logic [31:0]    ram_span;
      a = acc.bus_address;
      res.target = cbm_pkg::TargetNone;
      res.mapped_address = '0;
      if (cart_cfg.cartridge_loaded) begin
         size_code = (cart_cfg.rom_size_code == 3'd7) ? 3'd6 : cart_cfg.rom_size_code;
         rom_span = (BankBytes << (size_code + 1)) - 1;
         if (a < 16'h8000) begin
            if (acc.op == OpWrite) begin
               res.target = cbm_pkg::TargetReg;
               res.mapped_address = 21'(a[14:13]);
               case (cbm_pkg::cbm_mbc_reg_type'(a[14:13]))
                  cbm_pkg::RegRamEnable:
                     mbc_state.ram_enabled = (acc.write_data[3:0] == cbm_pkg::RamEnableKey);
                  cbm_pkg::RegBankLow:  mbc_state.bank_low = acc.write_data[4:0];
                  cbm_pkg::RegBankHigh: mbc_state.bank_high = acc.write_data[1:0];
                  default:              mbc_state.advanced_mode = acc.write_data[0];
               endcase
            end else if (mbc_state.boot_overlay && a < 16'h0100) begin
               res.target = cbm_pkg::TargetBoot;
               res.mapped_address = 21'(a[7:0]);
            end else begin
               if (a < 16'h4000) begin
                  rom_bank = (cart_cfg.mapper_banked && mbc_state.advanced_mode) ?
                             {mbc_state.bank_high, 5'd0} : 7'd0;
               end else if (cart_cfg.mapper_banked) begin
                  rom_bank = {mbc_state.bank_high,
                              (mbc_state.bank_low == 5'd0) ? 5'd1 : mbc_state.bank_low};
               end else begin
                  rom_bank = 7'd1;
               end
               res.target = cbm_pkg::TargetRom;
               res.mapped_address = 21'({rom_bank, a[13:0]} & rom_span);
            end
         end else if (a >= 16'hA000 && a < 16'hC000) begin
            if (cart_cfg.ram_size_code != 2'd0) begin
               ram_bank = (cart_cfg.mapper_banked && mbc_state.advanced_mode) ?
                          mbc_state.bank_high : 2'd0;
               ram_span = (32'd1 << (2 * cart_cfg.ram_size_code + 9)) - 1;
               res.target = cbm_pkg::TargetRam;
               res.mapped_address = 21'({ram_bank, a[12:0]} & ram_span);
            end
         end else if (a == cbm_pkg::BootOverlayAddr) begin
            if (acc.op == OpWrite && acc.write_data != '0) mbc_state.boot_overlay = 1'b0;
            res.target = cbm_pkg::TargetReg;
            res.mapped_address = 21'(cbm_pkg::RegBootOverlay);
         end
      end
      res.ram_access_ok = cart_cfg.cartridge_loaded && cart_cfg.ram_size_code != 2'd0 &&
                          mbc_state.ram_enabled;
      return res;
   endfunction

   // mostly region-targeted accesses, the rest fully random
   function automatic cbm_pkg::cbm_item_type random_access(input bit boot_off_ok);
      cbm_pkg::cbm_item_type acc;
      int unsigned  roll;
      roll = $urandom_range(0, 99);
      acc.op = 1'($urandom_range(0, 1));
      acc.bus_address = 16'($urandom);
      acc.write_data = 8'($urandom);
      if (roll < 25) begin
         acc.op = OpWrite;
         acc.bus_address[15] = 1'b0;
         if (acc.bus_address[14:13] == 2'(cbm_pkg::RegRamEnable) && $urandom_range(0, 1) == 0)
            acc.write_data[3:0] = cbm_pkg::RamEnableKey;
         if (acc.bus_address[14:13] == 2'(cbm_pkg::RegBankLow) && $urandom_range(0, 3) == 0)
            acc.write_data[4:0] = 5'd0;
      end else if (roll < 55) begin
         acc.op = OpRead;
         acc.bus_address[15] = 1'b0;
         if ($urandom_range(0, 2) == 0) acc.bus_address[15:9] = '0;
      end else if (roll < 75) begin
         acc.bus_address[15:13] = 3'b101;
      end else if (roll < 80) begin
         acc.bus_address = cbm_pkg::BootOverlayAddr;
      end
      if (!boot_off_ok && acc.bus_address == cbm_pkg::BootOverlayAddr) acc.write_data = '0;
      return acc;
   endfunction

   task automatic write_register(input cbm_pkg::cbm_csr_index_type idx,
                                 input logic [cbm_pkg::CsrWidth-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
   endtask

   task automatic apply_config(input cbm_pkg::cbm_cfg_type c);
      cart_cfg = c;
      config_count++;
      write_register(cbm_pkg::CsrCartridgeLoaded, cbm_pkg::CsrWidth'(c.cartridge_loaded));
      write_register(cbm_pkg::CsrMapperBanked, cbm_pkg::CsrWidth'(c.mapper_banked));
      write_register(cbm_pkg::CsrRomSizeCode, cbm_pkg::CsrWidth'(c.rom_size_code));
      write_register(cbm_pkg::CsrRamSizeCode, cbm_pkg::CsrWidth'(c.ram_size_code));
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_accesses.size() != 0 || req_bus.valid || expected_mappings.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) expected_mappings.push_back(map_access(offered_access));
         if (!req_bus.valid || req_bus.ready) begin
            if (req_gap_left != 0) begin
               req_bus.valid <= 1'b0;
               req_gap_left--;
            end else if (!steady_tail && pending_accesses.size() != 0 &&
                         $urandom_range(0, 7) == 0) begin
               req_gap_left = $urandom_range(0, 4);
               req_bus.valid <= 1'b0;
            end else if (pending_accesses.size() != 0) begin
               offered_access = pending_accesses.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.op <= offered_access.op;
               req_bus.bus_address <= offered_access.bus_address;
               req_bus.write_data <= offered_access.write_data;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_mappings.size() == 0) begin
               $error("unexpected transaction: target %0d, address %0h",
                      rsp_bus.target, rsp_bus.mapped_address);
               mismatches++;
            end else begin
               next_mapping = expected_mappings.pop_front();
               if (rsp_bus.target !== next_mapping.target) begin
                  $error("target: expected %0d, got %0d", next_mapping.target, rsp_bus.target);
                  mismatches++;
               end
               if (rsp_bus.mapped_address !== next_mapping.mapped_address) begin
                  $error("mapped_address: expected %0h, got %0h",
                         next_mapping.mapped_address, rsp_bus.mapped_address);
                  mismatches++;
               end
               if (rsp_bus.ram_access_ok !== next_mapping.ram_access_ok) begin
                  $error("ram_access_ok: expected %0d, got %0d",
                         next_mapping.ram_access_ok, rsp_bus.ram_access_ok);
                  mismatches++;
               end
               checked_count++;
               target_seen[int'(next_mapping.target)]++;
            end
         end
         if (rsp_hold_request) begin
            rsp_hold_left = LongHold;
            rsp_hold_request = 1'b0;
         end
         if (rsp_hold_left != 0) begin
            rsp_hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!steady_tail && $urandom_range(0, 6) == 0) begin
            rsp_hold_left = $urandom_range(0, 4);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles with no transaction
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          csr_write_enable) begin
         idle_cycles <= 0;
      end else if (idle_cycles == StallLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      cbm_pkg::cbm_cfg_type phase_cfg;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.op = OpRead;
      req_bus.bus_address = '0;
      req_bus.write_data = '0;
      rsp_bus.ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      cart_cfg = '0;
      mbc_state = '0;
      mbc_state.boot_overlay = 1'b1;
      rsp_hold_request = 1'b0;
      steady_tail = 1'b0;
      idle_cycles = 0;
      mismatches = 0;
      checked_count = 0;
      config_count = 0;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // no cartridge: everything unmapped, writes ignored
      pending_accesses.push_back('{OpRead, 16'h0000, 8'h00});
      pending_accesses.push_back('{OpWrite, 16'h0000, 8'h0A});
      pending_accesses.push_back('{OpWrite, 16'hFF50, 8'h01});
      pending_accesses.push_back('{OpRead, 16'hA000, 8'h00});
      wait_drained();

      // banked, oversized rom code, largest ram
      apply_config('{1'b1, 1'b1, 3'd7, 2'd3});
      pending_accesses.push_back('{OpRead, 16'h0000, 8'hFF});
      pending_accesses.push_back('{OpRead, 16'h00FF, 8'h00});
      pending_accesses.push_back('{OpRead, 16'h0100, 8'h00});
      pending_accesses.push_back('{OpRead, 16'hFF50, 8'h00});
      pending_accesses.push_back('{OpWrite, 16'hFF50, 8'h00});
      pending_accesses.push_back('{OpRead, 16'hA000, 8'h00});
      pending_accesses.push_back('{OpWrite, 16'h0000, 8'h0A});
      pending_accesses.push_back('{OpRead, 16'hBFFF, 8'h00});
      pending_accesses.push_back('{OpWrite, 16'h1FFF, 8'hFF});
      pending_accesses.push_back('{OpWrite, 16'h0000, 8'hFA});
      pending_accesses.push_back('{OpWrite, 16'h2000, 8'h00});
      pending_accesses.push_back('{OpRead, 16'h4000, 8'h00});
      pending_accesses.push_back('{OpWrite, 16'h3FFF, 8'hFF});
      pending_accesses.push_back('{OpWrite, 16'h4000, 8'hFF});
      pending_accesses.push_back('{OpRead, 16'h7FFF, 8'h00});
      pending_accesses.push_back('{OpWrite, 16'h6000, 8'h01});
      pending_accesses.push_back('{OpRead, 16'h3FFF, 8'h00});
      pending_accesses.push_back('{OpRead, 16'hBFFF, 8'h00});
      pending_accesses.push_back('{OpWrite, 16'hA000, 8'h5A});
      pending_accesses.push_back('{OpRead, 16'h8000, 8'h00});
      pending_accesses.push_back('{OpRead, 16'hFFFF, 8'h00});
      pending_accesses.push_back('{OpWrite, 16'h7FFF, 8'hFE});
      pending_accesses.push_back('{OpRead, 16'hC000, 8'h00});
      wait_drained();

      for (int p = 0; p < NumPhases; p++) begin
         case (p)
            0: phase_cfg = '{1'b1, 1'b1, 3'd0, 2'd1};
            1: phase_cfg = '{1'b1, 1'b0, 3'd6, 2'd2};
            2: phase_cfg = '{1'b0, 1'b1, 3'd3, 2'd3};
            3: phase_cfg = '{1'b1, 1'b1, 3'd7, 2'd3};
            4: phase_cfg = '{1'b1, 1'b1, 3'd2, 2'd0};
            default: begin
               phase_cfg.cartridge_loaded = ($urandom_range(0, 7) != 0);
               phase_cfg.mapper_banked = 1'($urandom_range(0, 1));
               phase_cfg.rom_size_code = 3'($urandom_range(0, 7));
               phase_cfg.ram_size_code = 2'($urandom_range(0, 3));
            end
         endcase
         apply_config(phase_cfg);
         if (p == NumPhases - 1) steady_tail = 1'b1;
         // receiver holds off while the sender keeps offering
         if (p == 3) rsp_hold_request = 1'b1;
         for (int i = 0; i < PhaseItems; i++) begin
            // sender pauses until every outstanding transaction has come back
            if (p == 5 && i == PhaseItems / 2) wait_drained();
            pending_accesses.push_back(random_access(p >= 6));
         end
         wait_drained();
      end

      repeat (10) @(negedge clock);
      if (expected_mappings.size() != 0) begin
         $error("%0d expected transactions never arrived", expected_mappings.size());
         mismatches++;
      end
      $display("checked %0d mapped accesses over %0d controller configurations",
               checked_count, config_count);
      $display("targets: %0d none, %0d boot, %0d rom, %0d ram, %0d register",
               target_seen[0], target_seen[1], target_seen[2], target_seen[3], target_seen[4]);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
